// File: rtl/isaac_pkg.sv
// isaac_pkg: shared types and constants of the isaac-32 generator
`timescale 1ns / 1ps

package isaac_pkg;

  localparam int unsigned POOL_WORDS_DEF = 256;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned CMD_W          = 2;
  localparam int unsigned SEED_IDX_W     = 8;
  localparam logic [WORD_W-1:0] FILL_WORD = 32'h2F2F_2F2F;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_ISSUE,
    PH_X,
    PH_A,
    PH_Y,
    PH_Z,
    PH_B
  } phase_t;

  typedef struct packed {
    logic   load_we;
    logic   acc_clear;
    logic   round_init;
    phase_t phase;
    logic   pool_rd;
    logic   idx_clear;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
    logic idx_last;
  } dp_stat_t;

endpackage

// File: rtl/isaac32_random_generator_top.sv
// isaac32_random_generator_top: isaac-32 generator with stream ports
`timescale 1ns / 1ps

// Items carry a command in in_tuser: load writes one seed word into the state
// memory; start clears the accumulators, runs two rounds and resets the draw
// index; draw reads the next pool word into a register and loads it into the
// output register once the output slot is free. Every 256th draw first runs a
// refill round of 256 steps, paced by the single read port of the state memory,
// which serves the four reads of a step one after another; each step passes
// through the states PX, PA, PY, PZ and PB, and in PY the new state word is
// formed and written. A new item is accepted only in the idle state, once the
// work of the previous item is done.
// State memory words never loaded read as 0x2F2F2F2F from reset on; draws are
// valid only after a start.
module isaac32_random_generator_top #(
  parameter int unsigned POOL_WORDS = isaac_pkg::POOL_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // seed_index[7:0], seed_word[39:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // random_word[31:0]
);
  import isaac_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  cmd_t     command;

  assign command = cmd_t'(in_tuser);

  isaac_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .command   (command),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  isaac_datapath #(
    .POOL_WORDS (POOL_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .seed_index  (in_tdata[7:0]),
    .seed_word   (in_tdata[39:8]),
    .stat        (dp_stat),
    .random_word (out_tdata)
  );

endmodule

// File: rtl/isaac_datapath.sv
// isaac_datapath: state memory, output pool, accumulators and round arithmetic
`timescale 1ns / 1ps

module isaac_datapath #(
  parameter int unsigned POOL_WORDS = isaac_pkg::POOL_WORDS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  isaac_pkg::dp_cmd_t                    cmd,
  input  logic [isaac_pkg::SEED_IDX_W-1:0]      seed_index,
  input  logic [isaac_pkg::WORD_W-1:0]          seed_word,
  output isaac_pkg::dp_stat_t                   stat,
  output logic [isaac_pkg::WORD_W-1:0]          random_word
);
  import isaac_pkg::*;

  localparam int unsigned AW   = $clog2(POOL_WORDS);
  localparam int unsigned HALF = POOL_WORDS / 2;

  logic [WORD_W-1:0] mem [POOL_WORDS];
  logic [WORD_W-1:0] pool [POOL_WORDS];
  logic [POOL_WORDS-1:0] vld_r;

  logic [WORD_W-1:0] rd_q_r;
  logic              vld_q_r;
  logic [WORD_W-1:0] mem_q;
  logic [WORD_W-1:0] pool_q_r;
  logic [WORD_W-1:0] out_data_r;

  logic [WORD_W-1:0] acc_a_r, acc_a_nxt;
  logic [WORD_W-1:0] acc_b_r, acc_b_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     r_r, r_nxt;
  logic [WORD_W-1:0] x_r;
  logic [WORD_W-1:0] y_r;

  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic [WORD_W-1:0] y_sum;
  logic [WORD_W-1:0] x_sum;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] y,
                                            input logic [1:0] ph);
    logic [WORD_W-1:0] m;
    case (ph)
      2'd0:    m = y ^ (y << 13);
      2'd1:    m = y ^ (y >> 6);
      2'd2:    m = y ^ (y << 2);
      default: m = y ^ (y >> 16);
    endcase
    return m;
  endfunction

  assign mem_q = vld_q_r ? rd_q_r : FILL_WORD;
  assign y_sum = acc_a_r + mem_q + acc_b_r;
  assign x_sum = x_r + mem_q;

  always_comb begin
    case (cmd.phase)
      PH_X:    rd_addr = r_r + AW'(HALF);
      PH_A:    rd_addr = x_r[AW+1:2];
      PH_Z:    rd_addr = y_r[AW+9:10];
      PH_B:    rd_addr = r_r + AW'(1);
      default: rd_addr = r_r;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = r_r;
    wd = y_sum;
    if (cmd.load_we) begin
      we = 1'b1;
      wa = seed_index[AW-1:0];
      wd = seed_word;
    end else if (cmd.phase == PH_Y) begin
      we = 1'b1;
    end
  end

  // state memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  // valid bits, an entry never written reads as the fill word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // output pool
  always_ff @(posedge clk) begin
    if (cmd.phase == PH_B) begin
      pool[r_r] <= x_sum;
    end
    if (cmd.pool_rd) begin
      pool_q_r <= pool[idx_r];
    end
  end

  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    r_nxt     = r_r;
    if (cmd.acc_clear) begin
      acc_a_nxt = '0;
      acc_b_nxt = '0;
      cnt_nxt   = '0;
    end
    if (cmd.round_init) begin
      cnt_nxt   = cnt_r + WORD_W'(1);
      acc_b_nxt = acc_b_r + cnt_r + WORD_W'(1);
      r_nxt     = '0;
    end
    if (cmd.phase == PH_A) begin
      acc_a_nxt = mix(acc_a_r, r_r[1:0]) + mem_q;
    end
    if (cmd.phase == PH_B) begin
      acc_b_nxt = x_sum;
      r_nxt     = r_r + AW'(1);
    end
    if (cmd.pool_rd) begin
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.idx_clear) begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_a_r <= '0;
      acc_b_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      r_r     <= '0;
    end else begin
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      r_r     <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase == PH_X) begin
      x_r <= mem_q;
    end
    if (cmd.phase == PH_Y) begin
      y_r <= y_sum;
    end
    if (cmd.out_load) begin
      out_data_r <= pool_q_r;
    end
  end

  assign stat.last_step = (r_r == AW'(POOL_WORDS - 1));
  assign stat.idx_last  = (idx_r == AW'(POOL_WORDS - 1));
  assign random_word    = out_data_r;

endmodule

// File: rtl/isaac_controller.sv
// isaac_controller: command sequencing, round stepping and output handshake
`timescale 1ns / 1ps

module isaac_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  isaac_pkg::cmd_t     command,
  output logic                out_valid,
  input  logic                out_ready,
  output isaac_pkg::dp_cmd_t  cmd,
  input  isaac_pkg::dp_stat_t stat
);
  import isaac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RINIT,
    S_P0,
    S_PX,
    S_PA,
    S_PY,
    S_PZ,
    S_PB,
    S_DRAW_RD,
    S_DRAW_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   rnd2_r, rnd2_nxt;
  logic   draw_r, draw_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    rnd2_nxt      = rnd2_r;
    draw_nxt      = draw_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.phase     = PH_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_LOAD: begin
              cmd.load_we = 1'b1;
            end
            CMD_START: begin
              cmd.acc_clear = 1'b1;
              rnd2_nxt      = 1'b1;
              draw_nxt      = 1'b0;
              state_nxt     = S_RINIT;
            end
            CMD_DRAW: begin
              if (stat.idx_last) begin
                rnd2_nxt  = 1'b0;
                draw_nxt  = 1'b1;
                state_nxt = S_RINIT;
              end else begin
                cmd.pool_rd = 1'b1;
                state_nxt   = S_DRAW_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RINIT: begin
        cmd.round_init = 1'b1;
        state_nxt      = S_P0;
      end
      S_P0: begin
        cmd.phase = PH_ISSUE;
        state_nxt = S_PX;
      end
      S_PX: begin
        cmd.phase = PH_X;
        state_nxt = S_PA;
      end
      S_PA: begin
        cmd.phase = PH_A;
        state_nxt = S_PY;
      end
      S_PY: begin
        cmd.phase = PH_Y;
        state_nxt = S_PZ;
      end
      S_PZ: begin
        cmd.phase = PH_Z;
        state_nxt = S_PB;
      end
      S_PB: begin
        cmd.phase = PH_B;
        if (!stat.last_step) begin
          state_nxt = S_PX;
        end else if (rnd2_r) begin
          rnd2_nxt  = 1'b0;
          state_nxt = S_RINIT;
        end else if (draw_r) begin
          state_nxt = S_DRAW_RD;
        end else begin
          cmd.idx_clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DRAW_RD: begin
        cmd.pool_rd = 1'b1;
        draw_nxt    = 1'b0;
        state_nxt   = S_DRAW_OUT;
      end
      S_DRAW_OUT: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rnd2_r      <= 1'b0;
      draw_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd2_r      <= rnd2_nxt;
      draw_r      <= draw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: test/isaac_checker.sv
// isaac_checker: watches both channels, predicts each draw and compares results
`timescale 1ns / 1ps

module isaac_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // seed_index[7:0], seed_word[39:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // random_word[31:0]
  output int          mismatches,
  output int          pending_words
);
  import isaac_pkg::*;

  localparam int WORDS = POOL_WORDS_DEF;

  logic [WORD_W-1:0] seed_mem [WORDS];
  logic [WORD_W-1:0] pool_mem [WORDS];
  logic [WORD_W-1:0] mix_a;
  logic [WORD_W-1:0] mix_b;
  logic [WORD_W-1:0] round_cnt;
  logic [7:0]        draw_pos;
  logic [WORD_W-1:0] expected_words [$];
  int                fail_cnt;

  function automatic void isaac_round();
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    round_cnt = round_cnt + 1;
    mix_b = mix_b + round_cnt;
    for (int r = 0; r < WORDS; r++) begin
      x = seed_mem[r];
      case (r % 4)
        0: y = mix_a ^ (mix_a << 13);
        1: y = mix_a ^ (mix_a >> 6);
        2: y = mix_a ^ (mix_a << 2);
        default: y = mix_a ^ (mix_a >> 16);
      endcase
      y = y + seed_mem[(r + WORDS / 2) % WORDS];
      mix_a = y;
      y = y + seed_mem[x[9:2]] + mix_b;
      seed_mem[r] = y;
      x = x + seed_mem[y[17:10]];
      mix_b = x;
      pool_mem[r] = x;
    end
  endfunction

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    logic [7:0]        slot;
    if (!rst_n) begin
      for (int i = 0; i < WORDS; i++) begin
        seed_mem[i] = FILL_WORD;
        pool_mem[i] = '0;
      end
      mix_a = '0;
      mix_b = '0;
      round_cnt = '0;
      draw_pos = '0;
      expected_words.delete();
      fail_cnt = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_LOAD: seed_mem[in_tdata[7:0]] = in_tdata[39:8];
          CMD_START: begin
            mix_a = '0;
            mix_b = '0;
            round_cnt = '0;
            isaac_round();
            isaac_round();
            draw_pos = '0;
          end
          CMD_DRAW: begin
            slot = draw_pos;
            draw_pos = draw_pos + 8'd1;
            // wrap refills the pool before the word is read
            if (draw_pos == 8'd0) isaac_round();
            expected_words.push_back(pool_mem[slot]);
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected random_word %h", out_tdata);
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want) begin
            if (fail_cnt < 10)
              $display("random_word mismatch: expected %h got %h", want, out_tdata);
            fail_cnt++;
          end
        end
      end
    end
    mismatches <= fail_cnt;
    pending_words <= expected_words.size();
  end

endmodule

// File: test/tb.sv
// tb: stimulus, handshake pacing and verdict for the isaac-32 generator
`timescale 1ns / 1ps

module tb;
  import isaac_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS = 1000;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // seed_index[7:0], seed_word[39:8]
  logic [1:0]  in_tuser;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // random_word[31:0]
  int          mismatches;
  int          pending_words;
  int          sent_items;
  int          quiet_cycles = 0;
  bit          calm;

  isaac32_random_generator_top dut (.*);

  isaac_checker u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input int unsigned idx,
                           input logic [31:0] word);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {word, idx[7:0]};
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_UNUSED) sent_items++;
    if (sent_items >= ITEMS * 4 / 5) calm = 1'b1;
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_LOAD;
    calm = 1'b0;
    sent_items = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, then start and draws, load after start, restart
    send_item(CMD_LOAD, 0, 32'h0000_0000);
    send_item(CMD_LOAD, 255, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 128, 32'h8000_0001);
    send_item(CMD_LOAD, 'h55, 32'hAAAA_AAAA);
    send_item(CMD_LOAD, 'hAA, 32'h5555_5555);
    send_item(CMD_UNUSED, 'hFF, 32'hFFFF_FFFF);
    send_item(CMD_START, $urandom_range(0, 255), $urandom);
    repeat (4) send_item(CMD_DRAW, $urandom_range(0, 255), $urandom);
    send_item(CMD_LOAD, 3, 32'h1234_5678);
    send_item(CMD_UNUSED, 0, 32'h0000_0000);
    repeat (3) send_item(CMD_DRAW, $urandom_range(0, 255), $urandom);
    send_item(CMD_START, $urandom_range(0, 255), $urandom);
    send_item(CMD_START, $urandom_range(0, 255), $urandom);
    repeat (3) send_item(CMD_DRAW, $urandom_range(0, 255), $urandom);

    // first run wraps the draw index at least once
    n = 520;
    while (sent_items < ITEMS) begin
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 7) == 0)
          send_item(CMD_UNUSED, $urandom_range(0, 255), $urandom);
        else
          send_item(CMD_LOAD, $urandom_range(0, 255), $urandom);
      end
      repeat (($urandom_range(0, 7) == 0) ? 2 : 1)
        send_item(CMD_START, $urandom_range(0, 255), $urandom);
      repeat (n) begin
        case ($urandom_range(0, 39))
          0: send_item(CMD_UNUSED, $urandom_range(0, 255), $urandom);
          1, 2: send_item(CMD_LOAD, $urandom_range(0, 255), $urandom);
          default: send_item(CMD_DRAW, $urandom_range(0, 255), $urandom);
        endcase
      end
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 120);
      if (n > ITEMS - sent_items) n = ITEMS - sent_items;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/isaac_pkg.sv
rtl/isaac_datapath.sv
rtl/isaac_controller.sv
rtl/isaac32_random_generator_top.sv
test/isaac_checker.sv
test/tb.sv
